// ===== hw/rtl/chunk_sector_table_allocator_top_defines.svh =====
// Assertion macros shared by the sector table allocator RTL.
`ifndef CHUNK_SECTOR_TABLE_ALLOCATOR_TOP_DEFINES_SVH
`define CHUNK_SECTOR_TABLE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CSTA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CSTA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/csta_pkg.sv =====
// Types, constants and helper functions of the sector table allocator.
package csta_pkg;

    // Table geometry and sector size
    localparam int SLOTS_PER_SIDE = 32;
    localparam int SECTOR_BYTES   = 4096;
    localparam int SLOT_COUNT     = SLOTS_PER_SIDE * SLOTS_PER_SIDE;
    localparam int IDX_W          = $clog2(SLOT_COUNT);
    localparam int SECTOR_SHIFT   = $clog2(SECTOR_BYTES);

    // Field widths
    localparam int REQ_W    = 2;
    localparam int COORD_W  = 5;
    localparam int DATA_W   = 24;
    localparam int SECTOR_W = 24;
    localparam int COUNT_W  = 8;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LOC_W    = SECTOR_W + COUNT_W;
    localparam int NEED_W   = DATA_W + 1;
    localparam int SUM_W    = DATA_W + 2;
    localparam int CAP_W    = COUNT_W + SECTOR_SHIFT;

    // Stream widths and input field positions
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;
    localparam int IN_X_LSB    = 0;
    localparam int IN_Z_LSB    = IN_X_LSB + COORD_W;
    localparam int IN_SIZE_LSB = IN_Z_LSB + COORD_W;
    localparam int IN_LSEC_LSB = IN_SIZE_LSB + DATA_W;
    localparam int IN_LCNT_LSB = IN_LSEC_LSB + SECTOR_W;
    localparam int IN_STMP_LSB = IN_LCNT_LSB + COUNT_W;

    // Protocol constants
    localparam int HEADER_BYTES      = 5;
    localparam int FIRST_DATA_SECTOR = 2;
    localparam int MAX_SECTORS       = 255;
    localparam logic [LOC_W-1:0] MIN_END = LOC_W'(FIRST_DATA_SECTOR) << COUNT_W;

    // Request codes (code 3 behaves as a lookup)
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TOO_BIG = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic decide;
        logic scan_init;
        logic scan_rd;
        logic fin;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic cnt_last;
        logic need_scan;
        logic out_free;
    } t_dp_sts;

    // Slot index of a coordinate pair
    function automatic logic [IDX_W-1:0] slot_index(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] z);
        return (IDX_W'(x) % IDX_W'(SLOTS_PER_SIDE)) +
               IDX_W'(SLOTS_PER_SIDE) * (IDX_W'(z) % IDX_W'(SLOTS_PER_SIDE));
    endfunction

endpackage

// ===== hw/rtl/csta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/csta_ctrl.sv =====
// Controller state machine of the sector table allocator.
`include "chunk_sector_table_allocator_top_defines.svh"

module csta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output csta_pkg::t_dp_cmd o_cmd,
    input  csta_pkg::t_dp_sts i_sts
);

    import csta_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence clearing, request intake, decision, scan and result
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.decide = 1'b1;
                if (i_sts.need_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last scan word lands in the running maximum here
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    `CSTA_ASSERT_NXT(a_accept_to_read, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == ST_READ, "accepted request did not go to read")
    `CSTA_ASSERT_IMP(a_fin_needs_room, i_clk, i_rst_n, o_cmd.fin, i_sts.out_free, "result written while output register busy")
    `CSTA_ASSERT_NXT(a_scan_runs_out, i_clk, i_rst_n, (r_state == ST_SCAN) && !i_sts.cnt_last, r_state == ST_SCAN, "scan left before last slot")

endmodule

// ===== hw/rtl/csta_dpath.sv =====
// Datapath of the sector table allocator: slot memories, scan and result register.
`include "chunk_sector_table_allocator_top_defines.svh"

module csta_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [csta_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic [csta_pkg::REQ_W-1:0]           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [csta_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic [csta_pkg::STATUS_W-1:0]        o_m_tuser,
    input  csta_pkg::t_dp_cmd                    i_cmd,
    output csta_pkg::t_dp_sts                    o_sts
);

    import csta_pkg::*;

    // Request fields
    logic [COORD_W-1:0]  in_x;
    logic [COORD_W-1:0]  in_z;
    logic [IDX_W-1:0]    in_idx;

    logic [REQ_W-1:0]    r_req;
    logic [IDX_W-1:0]    r_idx;
    logic [DATA_W-1:0]   r_size;
    logic [SECTOR_W-1:0] r_lsec;
    logic [COUNT_W-1:0]  r_lcnt;
    logic [STAMP_W-1:0]  r_stamp;

    // Slot memories
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [LOC_W-1:0]    loc_wdata;
    logic [STAMP_W-1:0]  stamp_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [LOC_W-1:0]    loc_rdata;
    logic [STAMP_W-1:0]  stamp_rdata;

    // Sweep counter and decision
    logic [IDX_W-1:0]    r_cnt;
    logic [NEED_W-1:0]   need;
    logic [SUM_W-1:0]    need_cnt;
    logic [CAP_W-1:0]    cap;
    logic                too_big;
    logic                fits;

    logic [LOC_W-1:0]    r_old_loc;
    logic [STAMP_W-1:0]  r_old_stamp;
    logic                r_too_big;
    logic                r_fits;
    logic [COUNT_W-1:0]  r_new_cnt;

    // Scan
    logic                r_scan_rd_d;
    logic [LOC_W-1:0]    r_max_end;
    logic [LOC_W-1:0]    scan_end;

    // Result
    logic [SECTOR_W-1:0] new_start;
    logic [STATUS_W-1:0] res_status;
    logic [LOC_W-1:0]    res_loc;
    logic [STAMP_W-1:0]  res_stamp;
    logic                res_wr;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [LOC_W-1:0]    r_out_loc;
    logic [STAMP_W-1:0]  r_out_stamp;

    assign in_x   = i_s_tdata[IN_X_LSB +: COORD_W];
    assign in_z   = i_s_tdata[IN_Z_LSB +: COORD_W];
    assign in_idx = slot_index(in_x, in_z);

    // Capture request on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_s_tuser;
            r_idx   <= in_idx;
            r_size  <= i_s_tdata[IN_SIZE_LSB +: DATA_W];
            r_lsec  <= i_s_tdata[IN_LSEC_LSB +: SECTOR_W];
            r_lcnt  <= i_s_tdata[IN_LCNT_LSB +: COUNT_W];
            r_stamp <= i_s_tdata[IN_STMP_LSB +: STAMP_W];
        end
    end

    // Advance sweep counter for clearing and scanning
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clear_wr || i_cmd.scan_rd) begin
            if (o_sts.cnt_last) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
        end
    end

    // Work out sector count and whether the old place still fits
    always_comb begin
        need     = NEED_W'(r_size) + NEED_W'(HEADER_BYTES);
        need_cnt = (SUM_W'(need) + SUM_W'(SECTOR_BYTES - 1)) >> SECTOR_SHIFT;
        cap      = CAP_W'(loc_rdata[COUNT_W-1:0]) * CAP_W'(SECTOR_BYTES);
        too_big  = need_cnt > SUM_W'(MAX_SECTORS);
        fits     = SUM_W'(need) <= SUM_W'(cap);
    end

    // Hold the slot's old contents and the decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_old_loc   <= loc_rdata;
            r_old_stamp <= stamp_rdata;
            r_too_big   <= too_big;
            r_fits      <= fits;
            r_new_cnt   <= need_cnt[COUNT_W-1:0];
        end
    end

    // Track furthest end sector word over the scan
    assign scan_end = loc_rdata + (LOC_W'(loc_rdata[COUNT_W-1:0]) << COUNT_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_rd_d <= 1'b0;
        end else begin
            r_scan_rd_d <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_max_end <= MIN_END;
        end else if (r_scan_rd_d && (scan_end > r_max_end)) begin
            r_max_end <= scan_end;
        end
    end

    // Form the result and the slot write-back
    assign new_start = r_fits ? r_old_loc[LOC_W-1:COUNT_W] : r_max_end[LOC_W-1:COUNT_W];

    always_comb begin
        res_status = STAT_OK;
        res_loc    = r_old_loc;
        res_stamp  = r_old_stamp;
        res_wr     = 1'b0;
        case (r_req)
            REQ_LOAD: begin
                res_loc   = {r_lsec, r_lcnt};
                res_stamp = r_stamp;
                res_wr    = 1'b1;
            end
            REQ_STORE: begin
                if (r_too_big) begin
                    res_status = STAT_TOO_BIG;
                end else begin
                    res_loc   = {new_start, r_new_cnt};
                    res_stamp = r_stamp;
                    res_wr    = 1'b1;
                end
            end
            default: begin
                // lookup: a start below the first data sector means absent
                if (r_old_loc[LOC_W-1:COUNT_W] < SECTOR_W'(FIRST_DATA_SECTOR)) begin
                    res_status = STAT_ABSENT;
                    res_loc    = '0;
                    res_stamp  = '0;
                end
            end
        endcase
    end

    // Drive memory ports
    always_comb begin
        ram_we      = i_cmd.clear_wr || (i_cmd.fin && res_wr);
        ram_waddr   = i_cmd.clear_wr ? r_cnt : r_idx;
        loc_wdata   = i_cmd.clear_wr ? '0 : res_loc;
        stamp_wdata = i_cmd.clear_wr ? '0 : res_stamp;
        ram_re      = i_cmd.accept || i_cmd.scan_rd;
        ram_raddr   = i_cmd.scan_rd ? r_cnt : in_idx;
    end

    csta_ram #(
        .WIDTH (LOC_W),
        .DEPTH (SLOT_COUNT)
    ) u_loc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (loc_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (loc_rdata)
    );

    csta_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (SLOT_COUNT)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (stamp_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (stamp_rdata)
    );

    // Output register: load on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_status <= res_status;
            r_out_loc    <= res_loc;
            r_out_stamp  <= res_stamp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {r_out_stamp, r_out_loc[COUNT_W-1:0], r_out_loc[LOC_W-1:COUNT_W]};

    // Status to controller
    assign o_sts.cnt_last  = r_cnt == IDX_W'(SLOT_COUNT - 1);
    assign o_sts.need_scan = (r_req == REQ_STORE) && !too_big && !fits;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    `CSTA_ASSERT_NXT(a_max_monotonic, i_clk, i_rst_n, r_scan_rd_d, r_max_end >= $past(r_max_end), "furthest end decreased during scan")

endmodule

// ===== hw/rtl/chunk_sector_table_allocator_top.sv =====
// Top level of the chunk sector table allocator.
// Keeps a 32 x 32 table of slot locations (start sector, sector count) and
// timestamps in two 1024-entry memories. After reset the block sweeps both
// memories to zero and takes no request until done. A load, a lookup, or
// a store that fits the slot's old sectors or is too big goes from accept
// through a read and a finish state to the result. A store that needs a new
// place reads every location word through the memory's single read port
// to find the furthest end sector, one slot per cycle. One request is in
// work at a time; a finished result waits in an output register while the
// next request is accepted.
module chunk_sector_table_allocator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request: req_type [1:0]
    input  logic [csta_pkg::REQ_W-1:0]         s_tuser,
    // request: local_x [4:0], local_z [9:5], data_size [33:10],
    // load_sector [57:34], load_count [65:58], stamp [97:66], zero pad
    input  logic [csta_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // result: status [1:0]
    output logic [csta_pkg::STATUS_W-1:0]      m_tuser,
    // result: sector_start [23:0], sector_count [31:24], slot_stamp [63:32]
    output logic [csta_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    import csta_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    csta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    csta_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench of the chunk sector table allocator.
module tb_top;
    import csta_pkg::*;

    // Undefined request code; the block serves it as a lookup
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int IDLE_PCT    = 33;
    localparam int RANDOM_REQS = 560;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic                hold_off;
        logic [REQ_W-1:0]    kind;
        logic [COORD_W-1:0]  x, z;
        logic [DATA_W-1:0]   size;
        logic [SECTOR_W-1:0] lsec;
        logic [COUNT_W-1:0]  lcnt;
        logic [STAMP_W-1:0]  stamp;
    } t_slot_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SECTOR_W-1:0] sector_start;
        logic [COUNT_W-1:0]  sector_count;
        logic [STAMP_W-1:0]  slot_stamp;
    } t_slot_res;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [STATUS_W-1:0]  m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // Shadow copy of the slot table
    logic [LOC_W-1:0]   loc_word  [SLOT_COUNT] = '{default: '0};
    logic [STAMP_W-1:0] slot_time [SLOT_COUNT] = '{default: '0};

    t_slot_req pending_q[$];
    t_slot_res result_q[$];
    int        n_offered   = 0;
    int        n_taken     = 0;
    int        bad_cnt     = 0;
    int        stall_count = 0;
    logic      quiet;

    // Stretch with no random idling on either side
    assign quiet = (n_taken >= 250) && (n_taken < 360);

    chunk_sector_table_allocator_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the shadow table and return the slot it reports
    function automatic t_slot_res apply_request(input t_slot_req r);
        logic [IDX_W-1:0] idx;
        logic [LOC_W-1:0] old_loc, w, reach, best;
        longint           need, sectors;
        int               i;
        t_slot_res        res;
        idx     = {r.z, r.x};
        old_loc = loc_word[idx];
        case (r.kind)
            REQ_LOAD: begin
                loc_word[idx]  = {r.lsec, r.lcnt};
                slot_time[idx] = r.stamp;
                res = '{STAT_OK, r.lsec, r.lcnt, r.stamp};
            end
            REQ_STORE: begin
                need    = longint'(r.size) + HEADER_BYTES;
                sectors = (need + SECTOR_BYTES - 1) / SECTOR_BYTES;
                if (sectors > MAX_SECTORS) begin
                    // reject and report the slot as it stands
                    res = '{STAT_TOO_BIG, old_loc[LOC_W-1:COUNT_W], old_loc[COUNT_W-1:0],
                            slot_time[idx]};
                end else begin
                    best = old_loc;
                    if (need > longint'(old_loc[COUNT_W-1:0]) * SECTOR_BYTES) begin
                        // find the furthest end word, wrapping at 32 bits
                        best = MIN_END;
                        for (i = 0; i < SLOT_COUNT; i++) begin
                            w     = loc_word[i];
                            reach = w + {16'h0000, w[COUNT_W-1:0], 8'h00};
                            if (reach > best) best = reach;
                        end
                    end
                    loc_word[idx]  = {best[LOC_W-1:COUNT_W], sectors[COUNT_W-1:0]};
                    slot_time[idx] = r.stamp;
                    res = '{STAT_OK, best[LOC_W-1:COUNT_W], sectors[COUNT_W-1:0], r.stamp};
                end
            end
            default: begin
                if (old_loc[LOC_W-1:COUNT_W] < FIRST_DATA_SECTOR)
                    res = '{STAT_ABSENT, '0, '0, '0};
                else
                    res = '{STAT_OK, old_loc[LOC_W-1:COUNT_W], old_loc[COUNT_W-1:0],
                            slot_time[idx]};
            end
        endcase
        return res;
    endfunction

    function automatic void queue_req(input logic [REQ_W-1:0] kind,
                                      input int unsigned x, z, size, lsec, lcnt, stamp,
                                      input logic hold_off);
        t_slot_req r;
        r.hold_off = hold_off;
        r.kind     = kind;
        r.x        = COORD_W'(x);
        r.z        = COORD_W'(z);
        r.size     = DATA_W'(size);
        r.lsec     = SECTOR_W'(lsec);
        r.lcnt     = COUNT_W'(lcnt);
        r.stamp    = stamp;
        pending_q.push_back(r);
    endfunction

    // Driver: present requests and drive the result ready at the falling edge
    always @(negedge i_clk) begin
        t_slot_req r;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            // hold the current request until it is taken
            if (n_taken == n_offered) begin
                if (n_offered < pending_q.size()) begin
                    r = pending_q[n_offered];
                    if ((quiet || $urandom_range(0, 99) >= IDLE_PCT) &&
                        !(r.hold_off && result_q.size() != 0)) begin
                        s_tvalid  <= 1'b1;
                        s_tuser   <= r.kind;
                        s_tdata   <= S_TDATA_W'({r.stamp, r.lcnt, r.lsec, r.size, r.z, r.x});
                        n_offered <= n_offered + 1;
                    end else begin
                        s_tvalid <= 1'b0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, then predict for each request taken
    always @(posedge i_clk) begin
        t_slot_res got, want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[23:0], m_tdata[31:24], m_tdata[63:32]};
                if (result_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("unexpected result: status %0d start %h count %0d stamp %h",
                                 got.status, got.sector_start, got.sector_count,
                                 got.slot_stamp);
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status || got.sector_start !== want.sector_start ||
                        got.sector_count !== want.sector_count ||
                        got.slot_stamp !== want.slot_stamp) begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display({"mismatch: status exp %0d got %0d, start exp %h got %h, ",
                                      "count exp %0d got %0d, stamp exp %h got %h"},
                                     want.status, got.status, want.sector_start,
                                     got.sector_start, want.sector_count, got.sector_count,
                                     want.slot_stamp, got.slot_stamp);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                result_q.push_back(apply_request(pending_q[n_taken]));
                n_taken <= n_taken + 1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        int          n, pick;
        int unsigned x, z, size, lsec;
        logic [REQ_W-1:0] kind;

        // Directed requests: absent slots, reuse, wrap of the end scan, size limits
        queue_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_LOAD, 31, 31, 0, 1, 3, 'hFFFF_FFFF, 1'b0);
        queue_req(REQ_LOOKUP, 31, 31, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_STORE, 31, 31, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_STORE, 0, 0, 0, 0, 0, 1, 1'b0);
        queue_req(REQ_LOAD, 5, 7, 0, 'hFF_FFFF, 'hFF, 0, 1'b0);
        queue_req(REQ_STORE, 1, 0, 4091, 0, 0, 2, 1'b0);
        queue_req(REQ_STORE, 1, 0, 4092, 0, 0, 3, 1'b0);
        queue_req(REQ_STORE, 1, 0, 4091, 0, 0, 4, 1'b0);
        queue_req(REQ_STORE, 2, 2, 1044475, 0, 0, 5, 1'b0);
        queue_req(REQ_STORE, 2, 2, 1044476, 0, 0, 6, 1'b0);
        queue_req(REQ_STORE, 3, 3, 'hFF_FFFF, 0, 0, 7, 1'b0);
        queue_req(REQ_SPARE, 2, 2, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_SPARE, 9, 9, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_LOAD, 10, 10, 0, 'hFF_FF00, 10, 'h1234_5678, 1'b0);
        queue_req(REQ_STORE, 11, 11, 100, 0, 0, 8, 1'b0);
        queue_req(REQ_LOAD, 0, 31, 0, 0, 5, 9, 1'b0);
        queue_req(REQ_STORE, 0, 31, 10, 0, 0, 10, 1'b0);
        queue_req(REQ_LOOKUP, 0, 31, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_LOAD, 31, 0, 0, 'hAB_CDEF, 0, 'hAAAA_AAAA, 1'b0);
        queue_req(REQ_LOOKUP, 31, 0, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_LOAD, 31, 31, 0, 0, 0, 0, 1'b0);
        queue_req(REQ_LOOKUP, 31, 31, 0, 0, 0, 0, 1'b0);

        // Random requests, mostly on a few hot slots so stores find old places
        for (n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      kind = REQ_LOAD;
            else if (pick < 58) kind = REQ_LOOKUP;
            else if (pick < 95) kind = REQ_STORE;
            else                kind = REQ_SPARE;
            if ($urandom_range(0, 99) < 70) begin
                x = $urandom_range(0, 3);
                z = $urandom_range(28, 31);
            end else begin
                x = $urandom;
                z = $urandom;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)      size = $urandom_range(0, 4 * SECTOR_BYTES);
            else if (pick < 85) size = $urandom_range(1040000, 1050000);
            else                size = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 10)      lsec = $urandom_range(0, 1);
            else if (pick < 60) lsec = $urandom_range(2, 4096);
            else                lsec = $urandom;
            queue_req(kind, x, z, size, lsec, $urandom, $urandom,
                      n == 0 || $urandom_range(0, 99) == 0);
        end

        // Hold reset low, then release it at a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain all results, then watch for strays
        while (n_taken < pending_q.size() || result_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/csta_pkg.sv
hw/rtl/csta_ram.sv
hw/rtl/csta_ctrl.sv
hw/rtl/csta_dpath.sv
hw/rtl/chunk_sector_table_allocator_top.sv
sim/tb_top.sv
